// File: rtl/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg
// shared widths, types and codes of the trial division prime test unit
// ----------------------------------------------------------------------------
package tdpt_pkg;

    localparam int VALUE_WIDTH   = 31;
    localparam int DIV_WIDTH     = VALUE_WIDTH / 2 + 1;
    localparam int SQ_WIDTH      = 2 * DIV_WIDTH;
    localparam int FIRST_DIVISOR = 2;
    localparam int FIRST_SQUARE  = FIRST_DIVISOR * FIRST_DIVISOR;

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [DIV_WIDTH-1:0]   divisor_t;
    typedef logic [SQ_WIDTH-1:0]    square_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic flush;
        logic publish;
        logic verdict;
    } cmd_t;

    typedef struct packed {
        logic below_first;
        logic bound_done;
        logic hit;
        logic pipe_empty;
    } status_t;

endpackage

// File: rtl/tdpt_dpath.sv
// ----------------------------------------------------------------------------
// tdpt_dpath
// candidate and divisor registers, square tracker, pipelined remainder unit
// and result register
// ----------------------------------------------------------------------------
module tdpt_dpath
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [tdpt_pkg::VALUE_WIDTH-1:0] candidate,
    input  tdpt_pkg::cmd_t                  cmd,
    output tdpt_pkg::status_t               sts,
    output logic [tdpt_pkg::VALUE_WIDTH-1:0] tested_value,
    output logic                            prime_flag
);

    tdpt_pkg::value_t   cand_reg;
    tdpt_pkg::divisor_t div_cnt_reg;
    tdpt_pkg::square_t  sq_reg;
    tdpt_pkg::value_t   tested_value_reg;
    logic               prime_flag_reg;

    tdpt_pkg::divisor_t rem_reg  [tdpt_pkg::VALUE_WIDTH];
    tdpt_pkg::divisor_t div_reg  [tdpt_pkg::VALUE_WIDTH];
    logic [tdpt_pkg::VALUE_WIDTH-1:0] vld_reg;

    tdpt_pkg::divisor_t rem_next [tdpt_pkg::VALUE_WIDTH];
    tdpt_pkg::divisor_t div_next [tdpt_pkg::VALUE_WIDTH];
    logic [tdpt_pkg::VALUE_WIDTH-1:0] vld_next;

    tdpt_pkg::divisor_t rem_in   [tdpt_pkg::VALUE_WIDTH];
    tdpt_pkg::divisor_t div_in   [tdpt_pkg::VALUE_WIDTH];
    logic [tdpt_pkg::VALUE_WIDTH-1:0] vld_in;
    logic [tdpt_pkg::DIV_WIDTH:0]     shf    [tdpt_pkg::VALUE_WIDTH];
    logic [tdpt_pkg::DIV_WIDTH:0]     diff   [tdpt_pkg::VALUE_WIDTH];

    // one quotient bit per stage, candidate msb first
    always_comb
    begin
        for (int k = 0; k < tdpt_pkg::VALUE_WIDTH; k++)
        begin
            if (k == 0)
            begin
                rem_in[k] = '0;
                div_in[k] = div_cnt_reg;
                vld_in[k] = cmd.issue;
            end
            else
            begin
                rem_in[k] = rem_reg[k-1];
                div_in[k] = div_reg[k-1];
                vld_in[k] = vld_reg[k-1];
            end
            shf[k]  = {rem_in[k], cand_reg[tdpt_pkg::VALUE_WIDTH-1-k]};
            diff[k] = shf[k] - {1'b0, div_in[k]};
            if (shf[k] >= {1'b0, div_in[k]})
            begin
                rem_next[k] = diff[k][tdpt_pkg::DIV_WIDTH-1:0];
            end
            else
            begin
                rem_next[k] = shf[k][tdpt_pkg::DIV_WIDTH-1:0];
            end
            div_next[k] = div_in[k];
            vld_next[k] = vld_in[k] && !cmd.flush && !cmd.load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < tdpt_pkg::VALUE_WIDTH; k++)
        begin
            rem_reg[k] <= rem_next[k];
            div_reg[k] <= div_next[k];
        end
    end

    // divisor counter with its square kept by adding 2d+1
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cand_reg    <= candidate;
            div_cnt_reg <= tdpt_pkg::DIV_WIDTH'(tdpt_pkg::FIRST_DIVISOR);
            sq_reg      <= tdpt_pkg::SQ_WIDTH'(tdpt_pkg::FIRST_SQUARE);
        end
        else if (cmd.issue)
        begin
            div_cnt_reg <= div_cnt_reg + tdpt_pkg::DIV_WIDTH'(1);
            sq_reg      <= sq_reg + tdpt_pkg::SQ_WIDTH'({div_cnt_reg, 1'b1});
        end
        if (cmd.publish)
        begin
            tested_value_reg <= cand_reg;
            prime_flag_reg   <= cmd.verdict;
        end
    end

    always_comb
    begin
        sts.below_first = cand_reg < tdpt_pkg::VALUE_WIDTH'(tdpt_pkg::FIRST_DIVISOR);
        sts.bound_done  = sq_reg > tdpt_pkg::SQ_WIDTH'(cand_reg);
        sts.hit         = vld_reg[tdpt_pkg::VALUE_WIDTH-1] &&
                          (rem_reg[tdpt_pkg::VALUE_WIDTH-1] == '0);
        sts.pipe_empty  = (vld_reg == '0);
    end

    assign tested_value = tested_value_reg;
    assign prime_flag   = prime_flag_reg;

endmodule

// File: rtl/tdpt_ctrl.sv
// ----------------------------------------------------------------------------
// tdpt_ctrl
// controller: input and output handshakes, scan sequencing, verdict
// ----------------------------------------------------------------------------
module tdpt_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  tdpt_pkg::status_t sts,
    output tdpt_pkg::cmd_t    cmd
);

    tdpt_pkg::state_t state_reg;
    tdpt_pkg::state_t state_next;
    logic             verdict_reg;
    logic             verdict_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             scan_end;
    logic             out_free;

    assign scan_end = sts.below_first || sts.hit || (sts.bound_done && sts.pipe_empty);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tdpt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tdpt_pkg::ST_SCAN;
                end
            end
            tdpt_pkg::ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = tdpt_pkg::ST_REPORT;
                end
            end
            tdpt_pkg::ST_REPORT:
            begin
                if (out_free)
                begin
                    state_next = tdpt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tdpt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        in_stall     = 1'b1;
        verdict_next = verdict_reg;
        case (state_reg)
            tdpt_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            tdpt_pkg::ST_SCAN:
            begin
                cmd.issue = !sts.bound_done && !sts.below_first && !sts.hit;
                cmd.flush = scan_end;
                if (scan_end)
                begin
                    verdict_next = !(sts.below_first || sts.hit);
                end
            end
            tdpt_pkg::ST_REPORT:
            begin
                cmd.publish = out_free;
            end
            default:
            begin
                cmd.flush = 1'b1;
            end
        endcase
        cmd.verdict = verdict_reg;
    end

    always_comb
    begin
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tdpt_pkg::ST_IDLE;
            verdict_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            verdict_reg   <= verdict_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/trial_division_prime_test_unit.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test_unit
// primality test of one 31-bit candidate per beat by trial division
//
// input channel: candidate with in_valid / in_stall, taken when valid and
// not stalled. output channel: tested_value and prime_flag with out_valid /
// out_stall. one result beat per input beat, in order.
// divisors 2, 3, ... are issued one per cycle while d*d <= candidate into a
// pipelined remainder unit of 31 stages, one quotient bit per stage; a zero
// remainder ends the scan early.
// a prime scans every divisor up to isqrt(candidate) and then drains the
// pipeline; a composite ends at its first zero remainder, so it reports sooner.
// throughput: one candidate at a time, so a new input beat is taken only after
// the last result leaves the controller; a new candidate is taken while a result waits.
// candidates 0 to 3 need no divisor, so none is issued for them.
// reset clears the controller and the pipeline valid bits; the block is idle.
// a stalled result holds in the output register, and the next result waits
// in the controller until that register is free.
// ----------------------------------------------------------------------------
module trial_division_prime_test_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [tdpt_pkg::VALUE_WIDTH-1:0] candidate,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [tdpt_pkg::VALUE_WIDTH-1:0] tested_value,
    output logic                             prime_flag
);

    tdpt_pkg::cmd_t    cmd;
    tdpt_pkg::status_t sts;

    tdpt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    tdpt_dpath u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .candidate    (candidate),
        .cmd          (cmd),
        .sts          (sts),
        .tested_value (tested_value),
        .prime_flag   (prime_flag)
    );

endmodule
